// ----- rtl/bgc_pkg.sv -----
`timescale 1ns / 1ps

package bgc_pkg;

    // Gate sequencer phases, coded as on the gate_phase output
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_OPENING = 2'd1,
        PH_OPEN    = 2'd2,
        PH_CLOSING = 2'd3
    } phase_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_RAISED_POSITION   = 3'd0;
    localparam logic [2:0] CFG_LOWERED_POSITION  = 3'd1;
    localparam logic [2:0] CFG_SLEW_STEP         = 3'd2;
    localparam logic [2:0] CFG_ARRIVE_MARGIN     = 3'd3;
    localparam logic [2:0] CFG_HOLD_TICKS        = 3'd4;
    localparam logic [2:0] CFG_PASS_DELAY_TICKS  = 3'd5;
    localparam logic [2:0] CFG_DEBOUNCE_TICKS    = 3'd6;
    localparam logic [2:0] CFG_TICKS_PER_SECOND  = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Reset values
    localparam logic [14:0] RAISED_RESET     = 15'd1700;
    localparam logic [14:0] LOWERED_RESET    = 15'd750;
    localparam logic [7:0]  SLEW_RESET       = 8'd5;
    localparam logic [7:0]  MARGIN_RESET     = 8'd5;
    localparam logic [15:0] HOLD_RESET       = 16'd300;
    localparam logic [15:0] PASS_RESET       = 16'd30;
    localparam logic [7:0]  DEBOUNCE_RESET   = 8'd10;
    localparam logic [6:0]  TPS_RESET        = 7'd100;
    localparam logic [14:0] POSITION_RESET   = 15'd810;
    localparam logic [14:0] POSITION_MAX     = 15'h7FFF;
    localparam logic [9:0]  SECONDS_LIMIT    = 10'd1023;

    typedef struct packed {
        logic [14:0] raised_position;
        logic [14:0] lowered_position;
        logic [7:0]  slew_step;
        logic [7:0]  arrive_margin;
        logic [15:0] hold_ticks;
        logic [15:0] pass_delay_ticks;
        logic [7:0]  debounce_ticks;
        logic [6:0]  ticks_per_second;
    } cfg_t;

    typedef struct packed {
        phase_t      gate_phase;
        logic [14:0] servo_position;
        logic        car_detected;
        logic [9:0]  parked_seconds;
        logic        timing_active;
        logic        play_farewell;
    } result_t;

endpackage

// ----- rtl/bgc_core.sv -----
`timescale 1ns / 1ps

module bgc_core #(
    parameter int MAX_SECONDS = 999
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           car_sensed,
    input  logic           start_timing,
    input  bgc_pkg::cfg_t  cfg,
    output bgc_pkg::result_t result
);

    // Seconds saturate at the smaller of the parameter and the counter range
    localparam logic [9:0] SEC_CAP = (MAX_SECONDS < 1023) ?
        10'(MAX_SECONDS) : bgc_pkg::SECONDS_LIMIT;

    bgc_pkg::phase_t phase_reg, phase_next;
    logic [14:0] position_reg, position_next;
    logic [14:0] target_reg, target_next;
    logic [7:0]  debounce_count_reg, debounce_count_next;
    logic        detected_reg, detected_next;
    logic [15:0] hold_count_reg, hold_count_next;
    logic [6:0]  subsecond_count_reg, subsecond_count_next;
    logic [9:0]  seconds_reg, seconds_next;
    logic        counting_reg, counting_next;

    logic [7:0]  debounce_inc;
    logic [15:0] hold_cut;
    logic        open_arrive;
    logic        close_arrive;
    logic        hold_done;
    logic [14:0] seq_position;
    logic        seq_counting;
    logic        farewell;
    logic [15:0] slew_sum;
    logic [6:0]  subsecond_inc;

    // Debounce the sensor
    always_comb
    begin
        debounce_inc = debounce_count_reg + 8'd1;
        if (car_sensed)
        begin
            if (debounce_inc >= cfg.debounce_ticks)
            begin
                detected_next       = 1'b1;
                debounce_count_next = '0;
            end
            else
            begin
                detected_next       = detected_reg;
                debounce_count_next = debounce_inc;
            end
        end
        else
        begin
            detected_next       = 1'b0;
            debounce_count_next = '0;
        end
    end

    // Arrival and hold conditions
    always_comb
    begin
        open_arrive  = ({1'b0, position_reg} + {8'd0, cfg.arrive_margin})
                       >= {1'b0, cfg.raised_position};
        close_arrive = {1'b0, position_reg}
                       <= ({1'b0, cfg.lowered_position} + {8'd0, cfg.arrive_margin});
        hold_cut = hold_count_reg;
        if (!detected_next && (hold_cut > cfg.pass_delay_ticks))
            hold_cut = cfg.pass_delay_ticks;
        if (hold_cut != 16'd0)
            hold_cut = hold_cut - 16'd1;
        hold_done = (hold_cut == 16'd0);
    end

    // Sequencer next state
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            bgc_pkg::PH_IDLE:
                if (detected_next)
                    phase_next = bgc_pkg::PH_OPENING;
            bgc_pkg::PH_OPENING:
                if (open_arrive)
                    phase_next = bgc_pkg::PH_OPEN;
            bgc_pkg::PH_OPEN:
                if (hold_done)
                    phase_next = bgc_pkg::PH_CLOSING;
            bgc_pkg::PH_CLOSING:
                if (close_arrive)
                    phase_next = bgc_pkg::PH_IDLE;
            default:
                phase_next = phase_reg;
        endcase
    end

    // Sequencer outputs: targets, position snaps, hold count, stop, farewell
    always_comb
    begin
        target_next     = target_reg;
        seq_position    = position_reg;
        hold_count_next = hold_count_reg;
        seq_counting    = counting_reg;
        farewell        = 1'b0;
        unique case (phase_reg)
            bgc_pkg::PH_IDLE:
                if (detected_next)
                    target_next = cfg.raised_position;
            bgc_pkg::PH_OPENING:
                if (open_arrive)
                begin
                    seq_position    = cfg.raised_position;
                    hold_count_next = cfg.hold_ticks;
                end
            bgc_pkg::PH_OPEN:
            begin
                hold_count_next = hold_cut;
                if (hold_done)
                    target_next = cfg.lowered_position;
            end
            bgc_pkg::PH_CLOSING:
                if (close_arrive)
                begin
                    seq_position = cfg.lowered_position;
                    seq_counting = 1'b0;
                    farewell     = 1'b1;
                end
            default:
                farewell = 1'b0;
        endcase
    end

    // Slew toward the target, saturating at both ends
    always_comb
    begin
        slew_sum = {1'b0, seq_position} + {8'd0, cfg.slew_step};
        if (seq_position < target_next)
            position_next = slew_sum[15] ? bgc_pkg::POSITION_MAX : slew_sum[14:0];
        else if (seq_position > target_next)
            position_next = (seq_position > {7'd0, cfg.slew_step}) ?
                seq_position - {7'd0, cfg.slew_step} : 15'd0;
        else
            position_next = seq_position;
    end

    // Parking seconds; a start wins over a stop on the same tick
    always_comb
    begin
        counting_next        = seq_counting | start_timing;
        seconds_next         = start_timing ? 10'd0 : seconds_reg;
        subsecond_inc        = subsecond_count_reg + 7'd1;
        subsecond_count_next = '0;
        if (counting_next)
        begin
            if (subsecond_inc >= cfg.ticks_per_second)
            begin
                if (seconds_next < SEC_CAP)
                    seconds_next = seconds_next + 10'd1;
            end
            else
                subsecond_count_next = subsecond_inc;
        end
    end

    always_comb
    begin
        result.gate_phase     = phase_next;
        result.servo_position = position_next;
        result.car_detected   = detected_next;
        result.parked_seconds = seconds_next;
        result.timing_active  = counting_next;
        result.play_farewell  = farewell;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= bgc_pkg::PH_IDLE;
            position_reg        <= bgc_pkg::POSITION_RESET;
            target_reg          <= bgc_pkg::LOWERED_RESET;
            debounce_count_reg  <= '0;
            detected_reg        <= 1'b0;
            hold_count_reg      <= '0;
            subsecond_count_reg <= '0;
            seconds_reg         <= '0;
            counting_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            position_reg        <= position_next;
            target_reg          <= target_next;
            debounce_count_reg  <= debounce_count_next;
            detected_reg        <= detected_next;
            hold_count_reg      <= hold_count_next;
            subsecond_count_reg <= subsecond_count_next;
            seconds_reg         <= seconds_next;
            counting_reg        <= counting_next;
        end
    end

endmodule

// ----- rtl/barrier_gate_controller_unit.sv -----
`timescale 1ns / 1ps

// Parking barrier controller. Each input transaction is one 10 ms tick carrying
// the car-sensor level and a start-timing pulse; each tick yields exactly one
// result transaction with the gate phase, servo pulse width, debounced
// detection flag, parked seconds, timing flag and farewell pulse. A tick is
// captured in an input register, processed by the state update once the
// result slot is free or being drained, and its result held in an output
// register until the result side takes it. One transaction is taken every
// clock cycle while the result side keeps up. The state update loop
// (debounce, sequencer, servo slew, seconds counter) sets that rate.
// Configuration registers are written through cfg_write/cfg_index/cfg_data and
// take effect on the next tick; write them only while no tick is in flight.
module barrier_gate_controller_unit #(
    parameter int MAX_SECONDS = 999
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        car_sensed,
    input  logic        start_timing,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  gate_phase,
    output logic [14:0] servo_position,
    output logic        car_detected,
    output logic [9:0]  parked_seconds,
    output logic        timing_active,
    output logic        play_farewell
);

    bgc_pkg::cfg_t cfg_reg;

    logic in_vld_reg;
    logic car_reg;
    logic start_reg;
    logic out_vld_reg;
    logic advance;

    bgc_pkg::result_t result;
    bgc_pkg::result_t res_reg;

    // Advance the held tick when the result slot is empty or being drained
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raised_position  <= bgc_pkg::RAISED_RESET;
            cfg_reg.lowered_position <= bgc_pkg::LOWERED_RESET;
            cfg_reg.slew_step        <= bgc_pkg::SLEW_RESET;
            cfg_reg.arrive_margin    <= bgc_pkg::MARGIN_RESET;
            cfg_reg.hold_ticks       <= bgc_pkg::HOLD_RESET;
            cfg_reg.pass_delay_ticks <= bgc_pkg::PASS_RESET;
            cfg_reg.debounce_ticks   <= bgc_pkg::DEBOUNCE_RESET;
            cfg_reg.ticks_per_second <= bgc_pkg::TPS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bgc_pkg::CFG_RAISED_POSITION:  cfg_reg.raised_position  <= cfg_data[14:0];
                bgc_pkg::CFG_LOWERED_POSITION: cfg_reg.lowered_position <= cfg_data[14:0];
                bgc_pkg::CFG_SLEW_STEP:        cfg_reg.slew_step        <= cfg_data[7:0];
                bgc_pkg::CFG_ARRIVE_MARGIN:    cfg_reg.arrive_margin    <= cfg_data[7:0];
                bgc_pkg::CFG_HOLD_TICKS:       cfg_reg.hold_ticks       <= cfg_data;
                bgc_pkg::CFG_PASS_DELAY_TICKS: cfg_reg.pass_delay_ticks <= cfg_data;
                bgc_pkg::CFG_DEBOUNCE_TICKS:   cfg_reg.debounce_ticks   <= cfg_data[7:0];
                bgc_pkg::CFG_TICKS_PER_SECOND: cfg_reg.ticks_per_second <= cfg_data[6:0];
                default:                       cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Input register: take a new tick whenever the slot is free or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            car_reg   <= car_sensed;
            start_reg <= start_timing;
        end
    end

    bgc_core #(
        .MAX_SECONDS (MAX_SECONDS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .car_sensed   (car_reg),
        .start_timing (start_reg),
        .cfg          (cfg_reg),
        .result       (result)
    );

    // Result register: hold while stalled, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= result;
    end

    assign out_valid      = out_vld_reg;
    assign gate_phase     = res_reg.gate_phase;
    assign servo_position = res_reg.servo_position;
    assign car_detected   = res_reg.car_detected;
    assign parked_seconds = res_reg.parked_seconds;
    assign timing_active  = res_reg.timing_active;
    assign play_farewell  = res_reg.play_farewell;

endmodule

// ----- rtl/bgc_checker.sv -----
`timescale 1ns / 1ps

module bgc_checker #(
    parameter int MAX_SECONDS = 999
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  gate_phase,
    input logic [14:0] servo_position,
    input logic [9:0]  parked_seconds,
    input logic        play_farewell
);

    localparam logic [9:0] SEC_CAP = (MAX_SECONDS < 1023) ?
        10'(MAX_SECONDS) : bgc_pkg::SECONDS_LIMIT;

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result does not change
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(gate_phase) && $stable(servo_position)
            && $stable(parked_seconds) && $stable(play_farewell))
        else $error("result changed while stalled");

    // Farewell only on the tick the gate returns to idle
    a_farewell_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && play_farewell |-> gate_phase == bgc_pkg::PH_IDLE)
        else $error("farewell outside idle phase");

    // Parked seconds never pass the saturation limit
    a_seconds_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> parked_seconds <= SEC_CAP)
        else $error("parked seconds above limit");

endmodule

bind barrier_gate_controller_unit bgc_checker #(
    .MAX_SECONDS (MAX_SECONDS)
) u_bgc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .gate_phase     (gate_phase),
    .servo_position (servo_position),
    .parked_seconds (parked_seconds),
    .play_farewell  (play_farewell)
);
